// ----- hw/rtl/sqia_pkg.sv -----
// Package for the service queue ID allocator: widths, command codes, cell control types.
`default_nettype none
package sqia_pkg;

    localparam int ID_W        = 4;
    localparam int LEN_W       = 5;
    localparam int CMD_W       = 2;
    localparam int DEF_MAX_IDS = 16;

    localparam logic [CMD_W-1:0] CMD_GIVE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEAT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KICK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BRIBE = 2'd3;

    // queue cell controls, already qualified by success
    typedef struct packed {
        logic give;
        logic seat;
        logic kick;
        logic bribe;
    } qctl_t;

    // free stack cell controls
    typedef struct packed {
        logic push;
        logic pop;
    } sctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/service_queue_id_allocator.sv -----
// Top level of the service queue ID allocator: command decode, counters, cell chains.
//
// channel  direction  ports
// s_       in         s_valid s_ready s_command s_buzzer_id
// m_       out        m_valid m_ready m_id_out m_success m_queue_length
//
// Each item is registered on take, then executed before the next is taken: matched
// over the queue cells while the cell chains shift. The match is a ripple OR along
// the queue chain. Reset clears the counters and the handshake state; cell contents
// need none. A result held in the output register stalls only the next execute step.
`default_nettype none
module service_queue_id_allocator #(
    parameter int MAX_IDS = sqia_pkg::DEF_MAX_IDS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [sqia_pkg::CMD_W-1:0]    s_command,
    input  wire [sqia_pkg::ID_W-1:0]     s_buzzer_id,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [sqia_pkg::ID_W-1:0]    m_id_out,
    output logic                         m_success,
    output logic [sqia_pkg::LEN_W-1:0]   m_queue_length
);

    localparam int IDX_W = $clog2(MAX_IDS);
    localparam int SID_W = (IDX_W > sqia_pkg::ID_W) ? IDX_W : sqia_pkg::ID_W;
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IDS);

    logic                       busy_reg;
    logic [sqia_pkg::CMD_W-1:0] cmd_reg;
    logic [SID_W-1:0]           named_reg;
    logic [CNT_W-1:0]           wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]           rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]           created_reg, created_next;
    logic                       m_valid_reg;
    logic [sqia_pkg::ID_W-1:0]  m_id_reg;
    logic                       m_success_reg;
    logic [sqia_pkg::LEN_W-1:0] m_len_reg;

    logic [SID_W-1:0] q_id [MAX_IDS];
    logic [SID_W-1:0] s_id [MAX_IDS];
    logic             hit  [MAX_IDS+1];

    logic             exec;
    logic             have_free;
    logic             fresh;
    logic             give_ok;
    logic             seat_ok;
    logic             found;
    logic             ok;
    logic [SID_W-1:0] give_id;
    logic [SID_W-1:0] push_id;
    logic [SID_W-1:0] id_res;
    sqia_pkg::qctl_t  qctl;
    sqia_pkg::sctl_t  sctl;

    assign s_ready = !busy_reg;
    assign exec    = busy_reg && (!m_valid_reg || m_ready);

    assign have_free = rcnt_reg != '0;
    assign fresh     = created_reg < CNT_MAX;
    assign give_id   = have_free ? s_id[0] : SID_W'(created_reg);
    assign give_ok   = (have_free || fresh) && (wcnt_reg < CNT_MAX);
    assign seat_ok   = wcnt_reg != '0;
    assign found     = hit[MAX_IDS];
    assign push_id   = (cmd_reg == sqia_pkg::CMD_SEAT) ? q_id[0] : named_reg;

    always_comb begin
        qctl         = '0;
        sctl         = '0;
        wcnt_next    = wcnt_reg;
        rcnt_next    = rcnt_reg;
        created_next = created_reg;
        ok           = 1'b0;
        id_res       = named_reg;
        case (cmd_reg)
            sqia_pkg::CMD_GIVE: begin
                ok     = give_ok;
                id_res = give_ok ? give_id : '0;
                if (exec && give_ok) begin
                    qctl.give = 1'b1;
                    wcnt_next = wcnt_reg + 1'b1;
                    if (have_free) begin
                        sctl.pop  = 1'b1;
                        rcnt_next = rcnt_reg - 1'b1;
                    end else begin
                        created_next = created_reg + 1'b1;
                    end
                end
            end
            sqia_pkg::CMD_SEAT: begin
                ok     = seat_ok;
                id_res = seat_ok ? q_id[0] : '0;
                if (exec && seat_ok) begin
                    qctl.seat = 1'b1;
                    sctl.push = 1'b1;
                    wcnt_next = wcnt_reg - 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            sqia_pkg::CMD_KICK: begin
                ok = found;
                if (exec && found) begin
                    qctl.kick = 1'b1;
                    sctl.push = 1'b1;
                    wcnt_next = wcnt_reg - 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            default: begin
                ok = found;
                if (exec && found) begin
                    qctl.bribe = 1'b1;
                end
            end
        endcase
    end

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < MAX_IDS; i++) begin : g_cells
        logic [SID_W-1:0] q_left, q_right, s_left, s_right;
        assign q_left  = (i == 0) ? named_reg : q_id[(i == 0) ? 0 : i-1];
        assign q_right = (i == MAX_IDS-1) ? '0 : q_id[(i == MAX_IDS-1) ? i : i+1];
        assign s_left  = (i == 0) ? push_id : s_id[(i == 0) ? 0 : i-1];
        assign s_right = (i == MAX_IDS-1) ? '0 : s_id[(i == MAX_IDS-1) ? i : i+1];

        sqia_qcell #(
            .IDX   (i),
            .SID_W (SID_W),
            .CNT_W (CNT_W)
        ) u_qcell (
            .aclk     (aclk),
            .ctl      (qctl),
            .count    (wcnt_reg),
            .give_id  (give_id),
            .named    (named_reg),
            .left_id  (q_left),
            .right_id (q_right),
            .hit_in   (hit[i]),
            .hit_out  (hit[i+1]),
            .id_o     (q_id[i])
        );

        sqia_scell #(
            .SID_W (SID_W)
        ) u_scell (
            .aclk     (aclk),
            .ctl      (sctl),
            .left_id  (s_left),
            .right_id (s_right),
            .id_o     (s_id[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            wcnt_reg    <= '0;
            rcnt_reg    <= '0;
            created_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wcnt_reg    <= wcnt_next;
            rcnt_reg    <= rcnt_next;
            created_reg <= created_next;
            if (s_valid && s_ready) begin
                busy_reg <= 1'b1;
            end else if (exec) begin
                busy_reg <= 1'b0;
            end
            if (exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            named_reg <= SID_W'(s_buzzer_id);
        end
        if (exec) begin
            m_id_reg      <= sqia_pkg::ID_W'(id_res);
            m_success_reg <= ok;
            m_len_reg     <= sqia_pkg::LEN_W'(wcnt_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_id_out       = m_id_reg;
    assign m_success      = m_success_reg;
    assign m_queue_length = m_len_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/sqia_qcell.sv -----
// One queue cell: holds a waiting ID, matches the named ID, shifts with its neighbors.
`default_nettype none
module sqia_qcell #(
    parameter int IDX   = 0,
    parameter int SID_W = 4,
    parameter int CNT_W = 5
) (
    input  wire                 aclk,
    input  sqia_pkg::qctl_t     ctl,
    input  wire [CNT_W-1:0]     count,
    input  wire [SID_W-1:0]     give_id,
    input  wire [SID_W-1:0]     named,
    input  wire [SID_W-1:0]     left_id,
    input  wire [SID_W-1:0]     right_id,
    input  wire                 hit_in,
    output logic                hit_out,
    output logic [SID_W-1:0]    id_o
);

    logic [SID_W-1:0] id_reg;
    logic [SID_W-1:0] id_next;
    logic             occupied;
    logic             is_tail;

    assign occupied = CNT_W'(IDX) < count;
    assign is_tail  = CNT_W'(IDX) == count;
    assign hit_out  = hit_in | (occupied && (id_reg == named));
    assign id_o     = id_reg;

    always_comb begin
        id_next = id_reg;
        if (ctl.give && is_tail) begin
            id_next = give_id;
        end else if (ctl.seat) begin
            id_next = right_id;
        end else if (ctl.kick && hit_out) begin
            id_next = right_id;
        end else if (ctl.bribe && !hit_in) begin
            id_next = left_id;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sqia_scell.sv -----
// One free stack cell: pushes take the left neighbor, pops take the right neighbor.
`default_nettype none
module sqia_scell #(
    parameter int SID_W = 4
) (
    input  wire                 aclk,
    input  sqia_pkg::sctl_t     ctl,
    input  wire [SID_W-1:0]     left_id,
    input  wire [SID_W-1:0]     right_id,
    output logic [SID_W-1:0]    id_o
);

    logic [SID_W-1:0] id_reg;
    logic [SID_W-1:0] id_next;

    assign id_o = id_reg;

    always_comb begin
        id_next = id_reg;
        if (ctl.push) begin
            id_next = left_id;
        end else if (ctl.pop) begin
            id_next = right_id;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

endmodule
`default_nettype wire
